// ===== src/itoa_pkg.sv =====
// Shared types, constants and the digit glyph table for the radix text converter.
package itoa_pkg;

    // Radix register bounds and reset value
    localparam int RADIX_W = 5;
    localparam logic [RADIX_W-1:0] MIN_RADIX   = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // Field widths
    localparam int NUMBER_W = 32;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;

    // Quotient bits retired by the divider in one cycle
    localparam int DIV_BITS = 8;

    // Special characters
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    // Source of the character loaded into the output register
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_SIGN,
        SEL_DIGIT,
        SEL_NUL
    } out_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     digit_done;
        logic     advance;
        out_sel_t sel;
    } itoa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic radix_ok;
        logic neg;
        logic q_zero;
        logic idx_zero;
        logic out_free;
    } itoa_status_t;

    // Map a digit value to its lower-case ASCII glyph
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d)
            4'h0: c = 7'h30;
            4'h1: c = 7'h31;
            4'h2: c = 7'h32;
            4'h3: c = 7'h33;
            4'h4: c = 7'h34;
            4'h5: c = 7'h35;
            4'h6: c = 7'h36;
            4'h7: c = 7'h37;
            4'h8: c = 7'h38;
            4'h9: c = 7'h39;
            4'ha: c = 7'h61;
            4'hb: c = 7'h62;
            4'hc: c = 7'h63;
            4'hd: c = 7'h64;
            4'he: c = 7'h65;
            4'hf: c = 7'h66;
            default: c = 7'h30;
        endcase
        return c;
    endfunction

endpackage

// ===== src/signed_int_to_radix_ascii.sv =====
// Top level of the signed integer to radix ASCII text converter.
// Converts one signed VALUE_WIDTH-bit integer per item into ASCII text in
// the base held by the radix register (2 to 16, reset 10), one character
// per result: an optional '-', the digits most significant first in
// '0'-'9' and 'a'-'f', then a NUL with last set. An out-of-range radix
// gives only the NUL. One item is converted at a time; the next item is
// taken once the NUL has been loaded into the output register, while it
// still waits to be taken. Each digit takes one full pass of the shared
// restoring divider over the magnitude, which retires eight quotient bits
// per cycle, and each character is read out of the registered digit
// buffer.
module signed_int_to_radix_ascii import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RADIX_W-1:0]  cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [NUMBER_W-1:0] number,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CHAR_W-1:0]   character,
    output logic                last
);

    itoa_cmd_t    cmd;
    itoa_status_t status;

    itoa_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .number    (number),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    // An accepted item keeps the input side closed until its run is queued
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted again right after an item");

    // The end marker is always the NUL character
    a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (character == CHAR_NUL))
        else $error("last set on a non-NUL character");

    // No divider step and no output load while the block takes a new item
    a_no_div_when_open: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !cmd.div_step && (cmd.sel == SEL_NONE))
        else $error("datapath busy while input is open");

endmodule

// ===== src/itoa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/itoa_ctrl.sv =====
// Controller state machine: sequences division, digit readback and character output.
module itoa_ctrl import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  itoa_status_t status,
    output itoa_cmd_t    cmd
);

    localparam int NCHUNK = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_SIGN,
        ST_DIGIT,
        ST_TERM
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   chunk_reg, chunk_next;
    logic            chunk_last;

    assign chunk_last = (chunk_reg == CW'(NCHUNK - 1));
    assign in_stall   = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        chunk_next     = chunk_reg;
        cmd.load       = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.digit_done = 1'b0;
        cmd.advance    = 1'b0;
        cmd.sel        = SEL_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                chunk_next = '0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.radix_ok ? ST_DIV : ST_TERM;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (chunk_last)
                begin
                    cmd.digit_done = 1'b1;
                    chunk_next     = '0;
                    if (status.q_zero)
                    begin
                        state_next = ST_PREP;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            ST_PREP:
            begin
                // wait here while the top digit is read out of the registered buffer
                state_next = status.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.sel    = SEL_SIGN;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.sel = SEL_DIGIT;
                    if (status.idx_zero)
                    begin
                        state_next = ST_TERM;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            ST_TERM:
            begin
                if (status.out_free)
                begin
                    cmd.sel    = SEL_NUL;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chunk_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
        end
    end

endmodule

// ===== src/itoa_dp.sv =====
// Datapath: radix register, magnitude, digit divider, digit buffer and output register.
module itoa_dp import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RADIX_W-1:0]  cfg_data,
    input  logic [NUMBER_W-1:0] number,
    input  itoa_cmd_t           cmd,
    output itoa_status_t        status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CHAR_W-1:0]   character,
    output logic                last
);

    localparam int NCHUNK = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W  = NCHUNK * DIV_BITS;
    localparam int AW     = $clog2(VALUE_WIDTH);

    logic [RADIX_W-1:0]     radix_reg;
    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg_reg;
    logic [PAD_W-1:0]       div_reg, div_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [AW-1:0]          wr_ptr_reg, idx_reg;
    logic [AW-1:0]          raddr;
    logic [DIGIT_W-1:0]     ram_rdata;
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;
    logic                   out_free;

    // Fit the input field to the working width
    generate
        if (VALUE_WIDTH <= NUMBER_W)
        begin : g_trunc
            assign value = number[VALUE_WIDTH-1:0];
        end
        else
        begin : g_ext
            assign value = {{(VALUE_WIDTH - NUMBER_W){1'b0}}, number};
        end
    endgenerate

    // Magnitude without overflow: the most negative value maps to its unsigned form
    assign mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

    // Radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_data;
        end
    end

    // Retire DIV_BITS quotient bits by restoring division
    always_comb
    begin
        logic [RADIX_W-1:0] t;
        div_next = div_reg;
        rem_next = rem_reg;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            t        = {rem_next, div_next[PAD_W-1]};
            div_next = {div_next[PAD_W-2:0], 1'b0};
            if (t >= radix_reg)
            begin
                rem_next    = DIGIT_W'(t - radix_reg);
                div_next[0] = 1'b1;
            end
            else
            begin
                rem_next = t[DIGIT_W-1:0];
            end
        end
    end

    // Dividend, remainder and digit pointers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg    <= PAD_W'(mag);
            rem_reg    <= '0;
            neg_reg    <= value[VALUE_WIDTH-1];
            wr_ptr_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_next;
            rem_reg <= cmd.digit_done ? '0 : rem_next;
            if (cmd.digit_done)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                idx_reg    <= wr_ptr_reg;
            end
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
    end

    // Read ahead one entry when the current digit is taken
    assign raddr = cmd.advance ? (idx_reg - 1'b1) : idx_reg;

    // Digit buffer, least significant digit at entry zero
    itoa_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .clk   (clk),
        .we    (cmd.digit_done),
        .waddr (wr_ptr_reg),
        .wdata (rem_next),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Output register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.sel != SEL_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.sel)
            SEL_SIGN:
            begin
                char_reg <= CHAR_MINUS;
                last_reg <= 1'b0;
            end
            SEL_DIGIT:
            begin
                char_reg <= glyph(ram_rdata);
                last_reg <= 1'b0;
            end
            SEL_NUL:
            begin
                char_reg <= CHAR_NUL;
                last_reg <= 1'b1;
            end
            default:
            begin
                char_reg <= char_reg;
                last_reg <= last_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // Status to the controller
    assign status.radix_ok = (radix_reg >= MIN_RADIX) && (radix_reg <= MAX_RADIX);
    assign status.neg      = neg_reg;
    assign status.q_zero   = (div_next == '0);
    assign status.idx_zero = (idx_reg == '0);
    assign status.out_free = out_free;

endmodule
